[rtl/core/swms_pkg.sv]
// ----------------------------------------------------------------------------
// swms_pkg
// Shared types and constants for the sliding-window mean and deviation block.
// ----------------------------------------------------------------------------
package swms_pkg;

    localparam int DEF_WINDOW   = 64;
    localparam int SAMPLE_W     = 24;
    localparam int MEAN_W       = 32;
    localparam int DEV_W        = 32;
    localparam int FILL_W       = 7;
    localparam int FRAC_W       = 8;
    localparam int DEV_SCALE_W  = 2 * FRAC_W;
    localparam int ROOT_IN_W    = 64;
    localparam int ROOT_STEPS   = ROOT_IN_W / 2;
    localparam int ADDER_W_DEF  = ROOT_IN_W + 1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SUM_ADD,
        ST_SUM_SUB,
        ST_SQN_LOAD,
        ST_SQN_MUL,
        ST_SQN_ADD,
        ST_SQO_LOAD,
        ST_SQO_MUL,
        ST_SQO_SUB,
        ST_MEAN_LOAD,
        ST_MEAN_DIV,
        ST_MEAN_SIGN,
        ST_DEN_LOAD,
        ST_DEN_MUL,
        ST_S2_LOAD,
        ST_S2_MUL,
        ST_NQ_LOAD,
        ST_NQ_MUL,
        ST_DIFF,
        ST_DEV_DIV,
        ST_ROOT_LOAD,
        ST_ROOT,
        ST_DONE
    } t_state;

    function automatic int f_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

[rtl/core/swms_addsub.sv]
// ----------------------------------------------------------------------------
// swms_addsub
// Shared adder/subtractor; carry out high on subtract means no borrow.
// ----------------------------------------------------------------------------
module swms_addsub #(
    parameter int WIDTH = swms_pkg::ADDER_W_DEF
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic             i_sub,
    output logic [WIDTH-1:0] o_sum,
    output logic             o_carry
);
    logic [WIDTH:0] full_sum;

    assign full_sum = {1'b0, i_a} + {1'b0, i_b ^ {WIDTH{i_sub}}} + (WIDTH + 1)'(i_sub);
    assign o_sum    = full_sum[WIDTH-1:0];
    assign o_carry  = full_sum[WIDTH];

endmodule

[rtl/core/sliding_window_mean_stddev.sv]
// ----------------------------------------------------------------------------
// sliding_window_mean_stddev
// Keeps the last WINDOW samples with a running sum and sum of squares, and
// after each sample reports the window mean and sample standard deviation
// (n-1 divisor), both with 8 fraction bits, plus the latest sample and fill
// count. Sums, products, quotients and the root all run through one shared
// adder under a small sequencer: squares and products bit-serially by
// shift-add, the mean and the scaled variance by restoring division, the
// deviation by a two-bits-per-step root. Removing the oldest sample is
// skipped while the window fills, and the deviation steps are skipped with
// a single sample held. Input is not ready while a sample is being worked
// on; a finished result sits in the output register until taken, and the
// next sample may be accepted meanwhile.
// ----------------------------------------------------------------------------
module sliding_window_mean_stddev #(
    parameter int WINDOW = swms_pkg::DEF_WINDOW
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_sample_valid,
    output logic                                o_sample_ready,
    input  logic signed [swms_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                o_result_valid,
    input  logic                                i_result_ready,
    output logic signed [swms_pkg::MEAN_W-1:0]  o_window_mean,
    output logic        [swms_pkg::DEV_W-1:0]   o_window_deviation,
    output logic signed [swms_pkg::SAMPLE_W-1:0] o_latest_sample,
    output logic        [swms_pkg::FILL_W-1:0]  o_fill_count
);
    import swms_pkg::*;

    localparam int LOG_W   = $clog2(WINDOW);
    localparam int CW      = $clog2(WINDOW + 1);
    localparam int SW      = SAMPLE_W + 1 + LOG_W;
    localparam int SQW     = 2 * SAMPLE_W - 1 + LOG_W;
    localparam int DW      = SQW + CW;
    localparam int DENW    = 2 * CW;
    localparam int AW      = f_max(f_max(2 * SW, DW), ROOT_IN_W + 1);
    localparam int MW      = SW;
    localparam int MEAN_NW = SW + FRAC_W;
    localparam int KW      = $clog2(DW + DEV_SCALE_W + 1);
    localparam int FEXT_W  = f_max(CW, FILL_W);

    t_state r_state, n_state;

    logic signed [SAMPLE_W-1:0] r_ring [WINDOW];
    logic        [LOG_W-1:0]    r_slot;
    logic        [CW-1:0]       r_count;
    logic signed [SW-1:0]       r_sum;
    logic        [SQW-1:0]      r_sq;
    logic                       r_full;
    logic signed [SAMPLE_W-1:0] r_v;
    logic signed [SAMPLE_W-1:0] r_old;

    logic [AW-1:0]        r_a;
    logic [MW-1:0]        r_m;
    logic [AW-1:0]        r_acc;
    logic [DENW-1:0]      r_den;
    logic [AW-1:0]        r_s2;
    logic [ROOT_IN_W-1:0] r_q;
    logic [ROOT_IN_W-1:0] r_res;
    logic [ROOT_IN_W-1:0] r_bit;
    logic [KW-1:0]        r_k;
    logic [MEAN_W-1:0]    r_mean;

    logic                       r_out_valid;
    logic signed [MEAN_W-1:0]   r_o_mean;
    logic        [DEV_W-1:0]    r_o_dev;
    logic signed [SAMPLE_W-1:0] r_o_latest;
    logic        [FILL_W-1:0]   r_o_fill;

    logic [AW-1:0]       add_a, add_b, add_res;
    logic                add_sub, add_carry;
    logic                in_accept, out_free, k_last, few_samples;
    logic [SAMPLE_W-1:0] mag_v, mag_old;
    logic [SW-1:0]       mag_sum;
    logic [FEXT_W-1:0]   count_ext;
    logic [LOG_W-1:0]    n_slot;

    assign o_sample_ready = (r_state == ST_IDLE);
    assign in_accept      = i_sample_valid && o_sample_ready;
    assign out_free       = !r_out_valid || i_result_ready;
    assign k_last         = (r_k == '0);
    assign few_samples    = (r_count < CW'(2));
    assign n_slot         = (r_slot == LOG_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
    assign count_ext      = FEXT_W'(r_count);

    assign mag_v   = r_v[SAMPLE_W-1] ? (~r_v + 1'b1) : r_v;
    assign mag_old = r_old[SAMPLE_W-1] ? (~r_old + 1'b1) : r_old;
    assign mag_sum = r_sum[SW-1] ? (~r_sum + 1'b1) : r_sum;

    swms_addsub #(
        .WIDTH (AW)
    ) u_swms_addsub (
        .i_a     (add_a),
        .i_b     (add_b),
        .i_sub   (add_sub),
        .o_sum   (add_res),
        .o_carry (add_carry)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_sample_valid) n_state = ST_SUM_ADD;
            ST_SUM_ADD:   n_state = r_full ? ST_SUM_SUB : ST_SQN_LOAD;
            ST_SUM_SUB:   n_state = ST_SQN_LOAD;
            ST_SQN_LOAD:  n_state = ST_SQN_MUL;
            ST_SQN_MUL:   if (k_last) n_state = ST_SQN_ADD;
            ST_SQN_ADD:   n_state = r_full ? ST_SQO_LOAD : ST_MEAN_LOAD;
            ST_SQO_LOAD:  n_state = ST_SQO_MUL;
            ST_SQO_MUL:   if (k_last) n_state = ST_SQO_SUB;
            ST_SQO_SUB:   n_state = ST_MEAN_LOAD;
            ST_MEAN_LOAD: n_state = ST_MEAN_DIV;
            ST_MEAN_DIV:  if (k_last) n_state = ST_MEAN_SIGN;
            ST_MEAN_SIGN: n_state = few_samples ? ST_DONE : ST_DEN_LOAD;
            ST_DEN_LOAD:  n_state = ST_DEN_MUL;
            ST_DEN_MUL:   if (k_last) n_state = ST_S2_LOAD;
            ST_S2_LOAD:   n_state = ST_S2_MUL;
            ST_S2_MUL:    if (k_last) n_state = ST_NQ_LOAD;
            ST_NQ_LOAD:   n_state = ST_NQ_MUL;
            ST_NQ_MUL:    if (k_last) n_state = ST_DIFF;
            ST_DIFF:      n_state = ST_DEV_DIV;
            ST_DEV_DIV:   if (k_last) n_state = ST_ROOT_LOAD;
            ST_ROOT_LOAD: n_state = ST_ROOT;
            ST_ROOT:      if (k_last) n_state = ST_DONE;
            ST_DONE:      if (out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (r_state)
            ST_SUM_ADD: begin
                add_a = AW'(r_sum);
                add_b = AW'(r_v);
            end
            ST_SUM_SUB: begin
                add_a   = AW'(r_sum);
                add_b   = AW'(r_old);
                add_sub = 1'b1;
            end
            ST_SQN_MUL, ST_SQO_MUL, ST_DEN_MUL, ST_S2_MUL, ST_NQ_MUL: begin
                add_a = r_acc;
                add_b = r_a;
            end
            ST_SQN_ADD: begin
                add_a = AW'(r_sq);
                add_b = r_acc;
            end
            ST_SQO_SUB: begin
                add_a   = AW'(r_sq);
                add_b   = r_acc;
                add_sub = 1'b1;
            end
            ST_MEAN_DIV, ST_DEV_DIV: begin
                add_a   = {r_acc[AW-2:0], r_a[AW-1]};
                add_b   = AW'(r_den);
                add_sub = 1'b1;
            end
            ST_MEAN_SIGN: begin
                add_b   = AW'(r_q[MEAN_W-1:0]);
                add_sub = 1'b1;
            end
            ST_DIFF: begin
                add_a   = r_acc;
                add_b   = r_s2;
                add_sub = 1'b1;
            end
            ST_ROOT: begin
                add_a   = r_acc;
                add_b   = AW'(r_res | r_bit);
                add_sub = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_accept) begin
                r_slot <= n_slot;
                r_full <= (r_count == CW'(WINDOW));
                if (r_count != CW'(WINDOW)) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (r_state == ST_SUM_ADD || r_state == ST_SUM_SUB) begin
                r_sum <= add_res[SW-1:0];
            end
            if (r_state == ST_SQN_ADD || r_state == ST_SQO_SUB) begin
                r_sq <= add_res[SQW-1:0];
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_v            <= i_sample;
            r_old          <= r_ring[r_slot];
            r_ring[r_slot] <= i_sample;
        end
        unique case (r_state)
            ST_SQN_LOAD: begin
                r_a   <= AW'(mag_v);
                r_m   <= MW'(mag_v);
                r_acc <= '0;
                r_k   <= KW'(SAMPLE_W - 1);
            end
            ST_SQO_LOAD: begin
                r_a   <= AW'(mag_old);
                r_m   <= MW'(mag_old);
                r_acc <= '0;
                r_k   <= KW'(SAMPLE_W - 1);
            end
            ST_SQN_MUL, ST_SQO_MUL, ST_DEN_MUL, ST_S2_MUL, ST_NQ_MUL: begin
                if (r_m[0]) begin
                    r_acc <= add_res;
                end
                r_a <= r_a << 1;
                r_m <= r_m >> 1;
                r_k <= r_k - 1'b1;
            end
            ST_MEAN_LOAD: begin
                r_a   <= AW'(mag_sum) << (AW - SW);
                r_den <= DENW'(r_count);
                r_acc <= '0;
                r_q   <= '0;
                r_k   <= KW'(MEAN_NW - 1);
            end
            ST_MEAN_DIV, ST_DEV_DIV: begin
                if (add_carry) begin
                    r_acc <= add_res;
                end else begin
                    r_acc <= {r_acc[AW-2:0], r_a[AW-1]};
                end
                r_a <= r_a << 1;
                r_q <= {r_q[ROOT_IN_W-2:0], add_carry};
                r_k <= r_k - 1'b1;
            end
            ST_MEAN_SIGN: begin
                r_mean <= r_sum[SW-1] ? add_res[MEAN_W-1:0] : r_q[MEAN_W-1:0];
            end
            ST_DEN_LOAD: begin
                r_a   <= AW'(r_count);
                r_m   <= MW'(r_count - 1'b1);
                r_acc <= '0;
                r_k   <= KW'(CW - 1);
            end
            ST_S2_LOAD: begin
                r_den <= r_acc[DENW-1:0];
                r_a   <= AW'(mag_sum);
                r_m   <= MW'(mag_sum);
                r_acc <= '0;
                r_k   <= KW'(SW - 1);
            end
            ST_NQ_LOAD: begin
                r_s2  <= r_acc;
                r_a   <= AW'(r_sq);
                r_m   <= MW'(r_count);
                r_acc <= '0;
                r_k   <= KW'(CW - 1);
            end
            ST_DIFF: begin
                // negative difference cannot arise; clamp to zero all the same
                r_a   <= add_carry ? (add_res << (AW - DW)) : '0;
                r_acc <= '0;
                r_q   <= '0;
                r_k   <= KW'(DW + DEV_SCALE_W - 1);
            end
            ST_ROOT_LOAD: begin
                r_acc <= AW'(r_q);
                r_res <= '0;
                r_bit <= ROOT_IN_W'(1) << (ROOT_IN_W - 2);
                r_k   <= KW'(ROOT_STEPS - 1);
            end
            ST_ROOT: begin
                if (add_carry) begin
                    r_acc <= add_res;
                    r_res <= (r_res >> 1) | r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_k   <= r_k - 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    r_o_mean   <= r_mean;
                    r_o_dev    <= few_samples ? '0 : r_res[DEV_W-1:0];
                    r_o_latest <= r_v;
                    r_o_fill   <= count_ext[FILL_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result_valid     = r_out_valid;
    assign o_window_mean      = r_o_mean;
    assign o_window_deviation = r_o_dev;
    assign o_latest_sample    = r_o_latest;
    assign o_fill_count       = r_o_fill;

endmodule

[rtl/core/swms_checker.sv]
// ----------------------------------------------------------------------------
// swms_checker
// Port-level checks for the sliding-window mean and deviation block.
// ----------------------------------------------------------------------------
module swms_checker #(
    parameter int WINDOW = swms_pkg::DEF_WINDOW
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [swms_pkg::MEAN_W-1:0]  i_mean,
    input logic        [swms_pkg::DEV_W-1:0]   i_dev,
    input logic signed [swms_pkg::SAMPLE_W-1:0] i_latest,
    input logic        [swms_pkg::FILL_W-1:0]  i_fill
);
    import swms_pkg::*;

    logic       in_acc, out_acc;
    logic [1:0] r_pend;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // transactions taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 2'(in_acc) - 2'(out_acc);
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("input ready straight after a transaction");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_mean) && $stable(i_dev)
            && $stable(i_latest) && $stable(i_fill))
        else $error("stalled result changed");

    a_single_sample_dev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (WINDOW < 128) && (i_fill == FILL_W'(1)) |-> i_dev == '0)
        else $error("deviation non-zero with one sample held");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> r_pend != 2'd0)
        else $error("result without a pending transaction");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("more than two transactions outstanding");

endmodule

bind sliding_window_mean_stddev swms_checker #(
    .WINDOW (WINDOW)
) u_swms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample_valid),
    .i_in_ready  (o_sample_ready),
    .i_out_valid (o_result_valid),
    .i_out_ready (i_result_ready),
    .i_mean      (o_window_mean),
    .i_dev       (o_window_deviation),
    .i_latest    (o_latest_sample),
    .i_fill      (o_fill_count)
);
